// ===== rtl/pbwa_pkg.sv =====
`timescale 1ns / 1ps

package pbwa_pkg;

  localparam int PITCH_W    = 15;
  localparam int BIN_IDX_W  = 7;
  localparam int CNT_W      = 24;
  localparam int SUM_W      = 39;
  localparam int ALL_W      = 32;
  localparam int SHIFT_W    = 13;
  localparam int WLEN_W     = 7;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIST_W     = 17;
  localparam int SPAN_SHIFT = 8;

  // Low edge of bin 0 in Q.8 semitones (23.5)
  localparam logic [DIST_W-1:0] BASE_Q8 = 17'd6016;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [ALL_W-1:0] ALL_MAX = {ALL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_ENABLE = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_TUNING_SHIFT  = 2'd2
  } cfg_reg_t;

  // Bins hit by one pitch: bin_hi when in range, bin_hi-1 too on a shared edge
  typedef struct packed {
    logic                 hit_lo;
    logic                 hit_hi;
    logic [BIN_IDX_W-1:0] bin_hi;
  } match_t;

endpackage

// ===== rtl/pbwa_if.sv =====
`timescale 1ns / 1ps

interface pbwa_in_if import pbwa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PITCH_W-1:0] pitch_q8;

  modport source (output valid, output pitch_q8, input ready);
  modport sink   (input valid, input pitch_q8, output ready);
endinterface

interface pbwa_out_if import pbwa_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [CNT_W-1:0]     bin_samples;
  logic [SUM_W-1:0]     bin_sum;
  logic [ALL_W-1:0]     all_samples;
  logic                 last_of_run;

  modport source (output valid, output bin_index, output bin_samples, output bin_sum,
                  output all_samples, output last_of_run, input ready);
  modport sink   (input valid, input bin_index, input bin_samples, input bin_sum,
                  input all_samples, input last_of_run, output ready);
endinterface

// ===== rtl/pitch_bin_window_averager.sv =====
// The first result of a pitch passes the F register, stage B, stage C and the output
// register; a second one (pitch on a shared bin edge) follows it.
// Throughput: one bin update per cycle unless the output stalls or an op is held, so one
// pitch per cycle, or two bin updates for a pitch on a shared edge; an update of the same
// bin as the one before is held while that one is in stage B, set by the read-modify-write
// loop through the bin memory. Reset, and every configuration write, clear all bins at once
// through per-bin valid bits; after reset the block accepts pitches in the next cycle.
`timescale 1ns / 1ps

module pitch_bin_window_averager import pbwa_pkg::*; #(
  parameter int NUM_BINS   = 96,
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  pbwa_in_if.sink               pitch,
  pbwa_out_if.source            result
);

  localparam int BIN_AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int HEAD_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CAP_W   = $clog2(WINDOW_MAX + 1);
  localparam int POS_W   = CAP_W + 1;
  localparam int WL_W    = (CAP_W > WLEN_W) ? CAP_W : WLEN_W;
  localparam int RING_D  = NUM_BINS * WINDOW_MAX;
  localparam int RING_AW = (RING_D > 1) ? $clog2(RING_D) : 1;
  localparam int WORD_W  = HEAD_W + SUM_W + CNT_W;

  // Configuration
  logic                      window_enable;
  logic [WLEN_W-1:0]         window_length;
  logic signed [SHIFT_W-1:0] tuning_shift;
  logic [WL_W-1:0]           wl_ext;
  logic [CAP_W-1:0]          cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_enable <= 1'b0;
      window_length <= WLEN_W'(1);
      tuning_shift  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_ENABLE: window_enable <= cfg_data[0];
        REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
        REG_TUNING_SHIFT:  tuning_shift  <= signed'(cfg_data[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  assign wl_ext = WL_W'(window_length);

  always_comb begin
    priority if (wl_ext == '0) begin
      cap = CAP_W'(1);
    end else if (wl_ext > WL_W'(WINDOW_MAX)) begin
      cap = CAP_W'(WINDOW_MAX);
    end else begin
      cap = CAP_W'(wl_ext);
    end
  end

  // Bin lookup
  match_t match;

  pbwa_bin_match #(.NUM_BINS(NUM_BINS)) u_match (
    .pitch_q8     (pitch.pitch_q8),
    .tuning_shift (tuning_shift),
    .match        (match)
  );

  // Pipeline control: stages B, C and the output advance together when the output slot frees up
  logic out_v;
  logic adv;
  logic f_v;
  logic f_need_lo;
  logic f_need_hi;
  logic [PITCH_W-1:0]   f_pitch;
  logic [BIN_IDX_W-1:0] f_bin_hi;
  logic [BIN_IDX_W-1:0] f_bin;
  logic                 f_last;
  logic                 issue;
  logic                 accept;

  logic                 b_v;
  logic [BIN_IDX_W-1:0] b_bin;
  logic [PITCH_W-1:0]   b_pitch;
  logic                 b_last;

  assign adv    = !out_v || result.ready;
  assign f_bin  = f_need_lo ? (f_bin_hi - BIN_IDX_W'(1)) : f_bin_hi;
  assign f_last = !(f_need_lo && f_need_hi);
  // Hold an op whose bin is still being read one stage ahead
  assign issue  = f_v && adv && !(b_v && (b_bin == f_bin));
  assign pitch.ready = !f_v || (issue && f_last);
  assign accept = pitch.valid && pitch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (accept) begin
      f_v <= match.hit_lo || match.hit_hi;
    end else if (issue && f_last) begin
      f_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pitch   <= pitch.pitch_q8;
      f_bin_hi  <= match.bin_hi;
      f_need_lo <= match.hit_lo;
      f_need_hi <= match.hit_hi;
    end else if (issue) begin
      f_need_lo <= 1'b0;
    end
  end

  // Bin memory: {head, sum, count} per bin, valid bits stand for the all-zero reset
  logic [WORD_W-1:0]   bin_mem [NUM_BINS];
  logic [WORD_W-1:0]   bin_rd;
  logic [NUM_BINS-1:0] bin_valid;
  logic                lw_v;
  logic [BIN_AW-1:0]   lw_bin;
  logic [WORD_W-1:0]   lw_word;
  logic                bin_we;
  logic [BIN_AW-1:0]   bin_wa;
  logic [WORD_W-1:0]   bin_wd;

  always_ff @(posedge clk) begin
    if (issue) begin
      bin_rd <= bin_mem[f_bin[BIN_AW-1:0]];
    end
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      bin_valid <= '0;
      lw_v      <= 1'b0;
    end else if (bin_we) begin
      bin_valid[bin_wa] <= 1'b1;
      lw_v              <= 1'b1;
    end
  end

  // Last write, forwarded to a read taken at the same edge
  always_ff @(posedge clk) begin
    if (bin_we) begin
      lw_bin  <= bin_wa;
      lw_word <= bin_wd;
    end
  end

  // Stage B: resolve bin state, read the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_bin   <= f_bin;
      b_pitch <= f_pitch;
      b_last  <= f_last;
    end
  end

  logic [WORD_W-1:0]  b_word;
  logic [CNT_W-1:0]   b_cnt;
  logic [SUM_W-1:0]   b_sum;
  logic [HEAD_W-1:0]  b_head;
  logic               b_full;
  logic [POS_W-1:0]   b_hc;
  logic [POS_W-1:0]   b_wrap;
  logic [HEAD_W-1:0]  b_pos;
  logic [SUM_W:0]     b_sp;
  logic [RING_AW-1:0] b_ring_addr;

  always_comb begin
    priority if (lw_v && (lw_bin == b_bin[BIN_AW-1:0])) begin
      b_word = lw_word;
    end else if (bin_valid[b_bin[BIN_AW-1:0]]) begin
      b_word = bin_rd;
    end else begin
      b_word = '0;
    end
  end

  assign {b_head, b_sum, b_cnt} = b_word;
  assign b_full = (b_cnt >= CNT_W'(cap));
  assign b_hc   = POS_W'(b_head) + POS_W'(b_cnt[CAP_W-1:0]);
  assign b_wrap = (b_hc >= POS_W'(cap)) ? (b_hc - POS_W'(cap)) : b_hc;
  assign b_pos  = b_full ? b_head : HEAD_W'(b_wrap);
  assign b_sp   = {1'b0, b_sum} + (SUM_W+1)'(b_pitch);
  assign b_ring_addr = RING_AW'(b_bin[BIN_AW-1:0]) * RING_AW'(WINDOW_MAX) + RING_AW'(b_pos);

  // Stage C: update and write back
  logic                 c_v;
  logic [BIN_IDX_W-1:0] c_bin;
  logic [PITCH_W-1:0]   c_pitch;
  logic                 c_last;
  logic [CNT_W-1:0]     c_cnt;
  logic [SUM_W-1:0]     c_sum;
  logic [SUM_W:0]       c_sp;
  logic [HEAD_W-1:0]    c_head;
  logic                 c_full;
  logic [RING_AW-1:0]   c_ring_addr;

  // Ring memory of window samples
  logic [PITCH_W-1:0] ring_mem [RING_D];
  logic [PITCH_W-1:0] ring_rd;
  logic               ring_we;
  logic [RING_AW-1:0] ring_wa;

  always_ff @(posedge clk) begin
    if (adv && b_v && window_enable) begin
      ring_rd <= ring_mem[b_ring_addr];
    end
    if (ring_we) begin
      ring_mem[ring_wa] <= c_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_bin       <= b_bin;
      c_pitch     <= b_pitch;
      c_last      <= b_last;
      c_cnt       <= b_cnt;
      c_sum       <= b_sum;
      c_sp        <= b_sp;
      c_head      <= b_head;
      c_full      <= b_full;
      c_ring_addr <= b_ring_addr;
    end
  end

  logic [ALL_W-1:0]  all_cnt;
  logic [ALL_W-1:0]  all_next;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SUM_W-1:0]  sum_add;
  logic [SUM_W:0]    sum_diff;
  logic [SUM_W-1:0]  sum_rep;
  logic [CAP_W-1:0]  head_inc;
  logic [HEAD_W-1:0] head_wrap;
  logic [CNT_W-1:0]  cnt_next;
  logic [SUM_W-1:0]  sum_next;
  logic [HEAD_W-1:0] head_next;
  logic              replace;

  assign cnt_inc   = (c_cnt == CNT_MAX) ? c_cnt : (c_cnt + CNT_W'(1));
  assign sum_add   = c_sp[SUM_W] ? SUM_MAX : c_sp[SUM_W-1:0];
  assign sum_diff  = c_sp - (SUM_W+1)'(ring_rd);
  assign sum_rep   = (c_sum >= SUM_W'(ring_rd))
                   ? (sum_diff[SUM_W] ? SUM_MAX : sum_diff[SUM_W-1:0])
                   : SUM_W'(c_pitch);
  assign head_inc  = CAP_W'(c_head) + CAP_W'(1);
  assign head_wrap = (head_inc == cap) ? '0 : HEAD_W'(head_inc);
  assign replace   = window_enable && c_full;

  always_comb begin
    if (replace) begin
      cnt_next  = CNT_W'(cap);
      sum_next  = sum_rep;
      head_next = head_wrap;
      all_next  = all_cnt;
    end else begin
      cnt_next  = cnt_inc;
      sum_next  = sum_add;
      head_next = c_head;
      all_next  = (all_cnt == ALL_MAX) ? all_cnt : (all_cnt + ALL_W'(1));
    end
  end

  assign bin_we  = adv && c_v;
  assign bin_wa  = c_bin[BIN_AW-1:0];
  assign bin_wd  = {head_next, sum_next, cnt_next};
  assign ring_we = adv && c_v && window_enable;
  assign ring_wa = c_ring_addr;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      all_cnt <= '0;
    end else if (bin_we) begin
      all_cnt <= all_next;
    end
  end

  // Output register
  logic [BIN_IDX_W-1:0] out_bin;
  logic [CNT_W-1:0]     out_cnt;
  logic [SUM_W-1:0]     out_sum;
  logic [ALL_W-1:0]     out_all;
  logic                 out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      out_bin  <= c_bin;
      out_cnt  <= cnt_next;
      out_sum  <= sum_next;
      out_all  <= all_next;
      out_last <= c_last;
    end
  end

  assign result.valid       = out_v;
  assign result.bin_index   = out_bin;
  assign result.bin_samples = out_cnt;
  assign result.bin_sum     = out_sum;
  assign result.all_samples = out_all;
  assign result.last_of_run = out_last;

endmodule

// ===== rtl/pbwa_bin_match.sv =====
`timescale 1ns / 1ps

module pbwa_bin_match import pbwa_pkg::*; #(
  parameter int NUM_BINS = 96
) (
  input  logic                      [PITCH_W-1:0] pitch_q8,
  input  logic signed               [SHIFT_W-1:0] tuning_shift,
  output match_t                                  match
);

  logic [DIST_W-1:0]    rel_q8;
  logic                 neg;
  logic                 on_edge;
  logic [BIN_IDX_W-1:0] bin;
  logic [BIN_IDX_W:0]   bin_ext;
  logic [BIN_IDX_W:0]   num_bins;

  // Distance above the low edge of bin 0, shift sign-extended
  assign rel_q8 = DIST_W'(pitch_q8) - BASE_Q8
                - {{(DIST_W-SHIFT_W){tuning_shift[SHIFT_W-1]}}, tuning_shift};

  assign neg      = rel_q8[DIST_W-1];
  assign on_edge  = (rel_q8[SPAN_SHIFT-1:0] == '0);
  assign bin      = rel_q8[SPAN_SHIFT+BIN_IDX_W-1:SPAN_SHIFT];
  assign bin_ext  = {1'b0, bin};
  assign num_bins = (BIN_IDX_W+1)'(NUM_BINS);

  always_comb begin
    match.bin_hi = bin;
    match.hit_hi = !neg && (bin_ext < num_bins);
    match.hit_lo = !neg && on_edge && (bin != '0) && (bin_ext <= num_bins);
  end

endmodule

// ===== rtl/pbwa_checker.sv =====
`timescale 1ns / 1ps

module pbwa_checker import pbwa_pkg::*; #(
  parameter int NUM_BINS = 96
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [BIN_IDX_W-1:0] bin_index,
  input logic [CNT_W-1:0]     bin_samples,
  input logic [SUM_W-1:0]     bin_sum,
  input logic [ALL_W-1:0]     all_samples,
  input logic                 last_of_run
);

  // A stalled transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(bin_index) && $stable(bin_samples)
      && $stable(bin_sum) && $stable(all_samples) && $stable(last_of_run))
    else $error("result changed while stalled");

  // An updated bin holds at least the sample just added
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> bin_samples != '0)
    else $error("updated bin reports no samples");

  // No bin holds more samples than all bins together
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ALL_W'(bin_samples) <= all_samples)
    else $error("bin count exceeds overall count");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (BIN_IDX_W+1)'(bin_index) < (BIN_IDX_W+1)'(NUM_BINS))
    else $error("bin index out of range");

endmodule

bind pitch_bin_window_averager pbwa_checker #(.NUM_BINS(NUM_BINS)) u_pbwa_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .bin_index   (result.bin_index),
  .bin_samples (result.bin_samples),
  .bin_sum     (result.bin_sum),
  .all_samples (result.all_samples),
  .last_of_run (result.last_of_run)
);
